>>> design/orsfe_pkg.sv
// Shared constants, codes and types of the on-off keyed remote switch frame encoder.
package orsfe_pkg;

  localparam int ADDRESS_BITS = 26;
  localparam int UNIT_BITS    = 4;
  localparam int DIM_BITS     = 4;
  localparam int ADDR_REG_W   = 26;
  localparam int PERIOD_W     = 10;
  localparam int CFG_DATA_W   = 26;
  localparam int CFG_IDX_W    = 1;
  localparam int TICK_W       = 16;
  localparam int FUNC_W       = 2;
  localparam int SHORT_W      = ADDRESS_BITS + 2 + UNIT_BITS;
  localparam int FRAME_W      = SHORT_W + DIM_BITS;
  localparam int IDX_W        = $clog2(FRAME_W + 2);
  localparam int IN_FIELD_W   = 1 + UNIT_BITS + DIM_BITS;
  localparam int IN_DATA_W    = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = 8;

  localparam logic [ADDR_REG_W-1:0] ADDRESS_RESET = '0;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET  = PERIOD_W'(260);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_GROUP = 2'd1,
    FUNC_UNIT  = 2'd2,
    FUNC_DIM   = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADDRESS = 1'b0,
    REG_PERIOD  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SYM_START = 3'd0,
    SYM_STOP  = 3'd1,
    SYM_ONE   = 3'd2,
    SYM_ZERO  = 3'd3,
    SYM_DIM   = 3'd4
  } sym_e;

  typedef struct packed {
    logic [FRAME_W-1:0] bits;
    func_e              kind;
    logic [IDX_W-1:0]   idx;
    logic [1:0]         phase;
    logic [TICK_W-1:0]  ticks;
    logic               pin;
    logic               active;
  } frame_state_t;

  typedef struct packed {
    sym_e sym;
    logic two_pulse;
    logic phase_done;
  } sym_info_t;

  typedef struct packed {
    logic pin;
    logic busy;
    logic accepted;
    logic frame_end;
  } result_t;

endpackage

>>> design/orsfe_timing.sv
// Symbol decode and phase length compare for the current frame position.
module orsfe_timing (
  input  orsfe_pkg::frame_state_t        state_i,
  input  logic [orsfe_pkg::PERIOD_W-1:0] period_i,
  output orsfe_pkg::sym_info_t           info_o
);
  import orsfe_pkg::*;

  logic [IDX_W-1:0]   n_bits;
  logic [IDX_W-1:0]   bit_pos;
  logic [FRAME_W-1:0] shifted;
  logic [TICK_W-1:0]  t;
  logic [TICK_W-1:0]  t_start;
  logic [TICK_W-1:0]  t_stop;
  logic [TICK_W-1:0]  t_five;
  logic [TICK_W-1:0]  len;
  logic [TICK_W-1:0]  ticks_inc;
  sym_e               sym;

  always_comb begin
    n_bits  = (state_i.kind == FUNC_DIM) ? IDX_W'(FRAME_W) : IDX_W'(SHORT_W);
    bit_pos = n_bits - state_i.idx;
    shifted = state_i.bits >> bit_pos;
    if (state_i.idx == '0) begin
      sym = SYM_START;
    end else if (state_i.idx > n_bits) begin
      sym = SYM_STOP;
    end else if (state_i.kind == FUNC_DIM && state_i.idx == IDX_W'(ADDRESS_BITS + 2)) begin
      sym = SYM_DIM;
    end else if (shifted[0]) begin
      sym = SYM_ONE;
    end else begin
      sym = SYM_ZERO;
    end
  end

  always_comb begin
    t       = (period_i == '0) ? TICK_W'(1) : TICK_W'(period_i);
    t_start = (t << 3) + (t << 1) + (t >> 1);
    t_stop  = (t << 5) + (t << 3);
    t_five  = (t << 2) + t;
    len     = t;
    if (state_i.phase[0]) begin
      case (sym)
        SYM_START: len = t_start;
        SYM_STOP:  len = t_stop;
        SYM_DIM:   len = t;
        SYM_ONE:   len = state_i.phase[1] ? t_five : t;
        SYM_ZERO:  len = state_i.phase[1] ? t : t_five;
        default:   len = t;
      endcase
    end
    ticks_inc = state_i.ticks + TICK_W'(1);
  end

  assign info_o.sym        = sym;
  assign info_o.two_pulse  = (sym != SYM_START) && (sym != SYM_STOP);
  assign info_o.phase_done = (ticks_inc >= len);

endmodule

>>> design/orsfe_frame.sv
// Frame state registers and the per-beat waveform update.
module orsfe_frame (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  orsfe_pkg::func_e                 func_i,
  input  logic                             switch_on_i,
  input  logic [orsfe_pkg::UNIT_BITS-1:0]  unit_i,
  input  logic [orsfe_pkg::DIM_BITS-1:0]   dim_level_i,
  input  logic [orsfe_pkg::ADDR_REG_W-1:0] address_i,
  input  logic [orsfe_pkg::PERIOD_W-1:0]   period_i,
  output orsfe_pkg::result_t               result_o
);
  import orsfe_pkg::*;

  frame_state_t        state_q;
  frame_state_t        state_d;
  sym_info_t           info;
  logic [SHORT_W-1:0]  short_bits;
  logic                acc;
  logic                fend;

  orsfe_timing u_timing (
    .state_i  (state_q),
    .period_i (period_i),
    .info_o   (info)
  );

  always_comb begin
    short_bits = {address_i[ADDRESS_BITS-1:0],
                  (func_i == FUNC_GROUP),
                  (func_i == FUNC_DIM) ? 1'b0 : switch_on_i,
                  (func_i == FUNC_GROUP) ? {UNIT_BITS{1'b0}} : unit_i};
    state_d = state_q;
    acc     = 1'b0;
    fend    = 1'b0;
    if (func_i != FUNC_TICK) begin
      if (!state_q.active) begin
        state_d.bits   = (func_i == FUNC_DIM) ? {short_bits, dim_level_i}
                                              : FRAME_W'(short_bits);
        state_d.kind   = func_i;
        state_d.idx    = '0;
        state_d.phase  = 2'd0;
        state_d.ticks  = '0;
        state_d.pin    = 1'b1;
        state_d.active = 1'b1;
        acc            = 1'b1;
      end
    end else if (state_q.active) begin
      state_d.ticks = state_q.ticks + TICK_W'(1);
      if (info.phase_done) begin
        state_d.ticks = '0;
        if (!state_q.phase[0]) begin
          state_d.phase = state_q.phase + 2'd1;
          state_d.pin   = 1'b0;
        end else if (state_q.phase == 2'd1 && info.two_pulse) begin
          state_d.phase = 2'd2;
          state_d.pin   = 1'b1;
        end else if (info.sym == SYM_STOP) begin
          state_d = '0;
          fend    = 1'b1;
        end else begin
          state_d.idx   = state_q.idx + IDX_W'(1);
          state_d.phase = 2'd0;
          state_d.pin   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign result_o.pin       = state_d.pin;
  assign result_o.busy      = state_d.active;
  assign result_o.accepted  = acc;
  assign result_o.frame_end = fend;

endmodule

>>> design/ook_remote_switch_frame_encoder_unit.sv
// Top level: config registers, input beat register, frame core and result register.
// A beat taken at the input passes through the input beat register and then the result register before it is presented.
// Throughput: one beat per cycle while the result side does not stall; the frame update is a single pass per beat.
// Backpressure on the result side stalls the input register and the frame core together.
// Reset clears the frame state and both beat valid flags; address resets to 0, period to 260.
module ook_remote_switch_frame_encoder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // switch_on [0], unit [4:1], dim_level [8:5], zero fill above
  input  logic [orsfe_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // func [1:0]
  input  logic [orsfe_pkg::FUNC_W-1:0]      s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // pin_level [0], busy_res [1], accepted [2], zero fill above
  output logic [orsfe_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  input  logic                              cfg_we_i,
  input  logic [orsfe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [orsfe_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import orsfe_pkg::*;

  logic [ADDR_REG_W-1:0] address_q;
  logic [PERIOD_W-1:0]   period_q;
  logic                  in_vld_q;
  func_e                 in_func_q;
  logic                  in_sw_q;
  logic [UNIT_BITS-1:0]  in_unit_q;
  logic [DIM_BITS-1:0]   in_dim_q;
  logic                  out_vld_q;
  result_t               out_q;
  result_t               result;
  logic                  out_free;
  logic                  step;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= ADDRESS_RESET;
      period_q  <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ADDRESS: address_q <= cfg_wdata_i[ADDR_REG_W-1:0];
        REG_PERIOD:  period_q  <= cfg_wdata_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_func_q <= func_e'(s_axis_tuser_i);
      in_sw_q   <= s_axis_tdata_i[0];
      in_unit_q <= s_axis_tdata_i[UNIT_BITS:1];
      in_dim_q  <= s_axis_tdata_i[UNIT_BITS+DIM_BITS:UNIT_BITS+1];
    end
  end

  orsfe_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .func_i      (in_func_q),
    .switch_on_i (in_sw_q),
    .unit_i      (in_unit_q),
    .dim_level_i (in_dim_q),
    .address_i   (address_q),
    .period_i    (period_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - 3){1'b0}}, out_q.accepted, out_q.busy, out_q.pin};
  assign m_axis_tlast_o  = out_q.frame_end;

endmodule

>>> design/orsfe_checker.sv
// Port-level checker for the frame encoder and its bind to the top level.
module orsfe_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [orsfe_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tlast_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2] |-> m_axis_tdata_o[0] && m_axis_tdata_o[1])
    else $error("accepted beat without busy and high pin");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> !m_axis_tdata_o[0] && !m_axis_tdata_o[1]
      && !m_axis_tdata_o[2])
    else $error("frame end beat not idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[1] |-> !m_axis_tdata_o[0])
    else $error("pin high while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled result beat changed");

endmodule

bind ook_remote_switch_frame_encoder_unit orsfe_checker u_orsfe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
